>>> sv/dfam_pkg.sv
`default_nettype none
package dfam_pkg;

  localparam int StateW = 4;
  localparam int SymW   = 8;
  localparam int SlotW  = 4;
  localparam int SizeW  = 5;
  localparam int StatW  = 2;
  localparam int FuncW  = 2;
  localparam int RegW   = 2;
  localparam int CfgW   = 5;
  localparam int SlotMax = 16;

  localparam logic [FuncW-1:0] FN_ALPHA  = 2'd0;
  localparam logic [FuncW-1:0] FN_TABLE  = 2'd1;
  localparam logic [FuncW-1:0] FN_SYMBOL = 2'd2;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [StatW-1:0] ST_IGNORED = 2'd2;

  localparam logic [RegW-1:0] REG_INITIAL    = 2'd0;
  localparam logic [RegW-1:0] REG_FINAL      = 2'd1;
  localparam logic [RegW-1:0] REG_ALPHA_SIZE = 2'd2;

  typedef struct packed {
    logic              is_symbol;
    logic              first;
    logic              found;
    logic [SlotW-1:0]  col;
    logic [StateW-1:0] row;
    logic [StateW-1:0] target;
  } cmd_t;

  typedef struct packed {
    logic [StateW-1:0] initial_state;
    logic [StateW-1:0] accept_state;
  } walk_cfg_t;

endpackage
`default_nettype wire

>>> sv/dfam_item_if.sv
`default_nettype none
interface dfam_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       first_of_string;
  logic [7:0] symbol;
  logic [3:0] column_index;
  logic [3:0] row_state;
  logic [3:0] target_state;

  modport source (
    output valid, func, first_of_string, symbol, column_index, row_state, target_state,
    input  ready
  );
  modport sink (
    input  valid, func, first_of_string, symbol, column_index, row_state, target_state,
    output ready
  );
endinterface
`default_nettype wire

>>> sv/dfam_result_if.sv
`default_nettype none
interface dfam_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] state_before;
  logic       accepted_before;
  logic [3:0] state_after;
  logic       accepted_after;
  logic [1:0] status;

  modport source (
    output valid, state_before, accepted_before, state_after, accepted_after, status,
    input  ready
  );
  modport sink (
    input  valid, state_before, accepted_before, state_after, accepted_after, status,
    output ready
  );
endinterface
`default_nettype wire

>>> sv/dfam_cfg_if.sv
`default_nettype none
interface dfam_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/dfam_front.sv
`default_nettype none
module dfam_front
  import dfam_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int NUM_STATES  = 16
) (
  input  wire logic             clk,
  dfam_item_if.sink             item,
  input  wire logic [SizeW-1:0] slot_limit,
  input  wire logic             q_full,
  output      logic             push,
  output      cmd_t             push_cmd
);

  localparam int AlphaDepth = (MAX_SYMBOLS < SlotMax) ? MAX_SYMBOLS : SlotMax;
  localparam int Rows       = (NUM_STATES < SlotMax) ? NUM_STATES : SlotMax;

  logic [SymW-1:0] alpha [AlphaDepth];
  logic            accept;
  logic            found;
  logic [SlotW-1:0] slot;
  logic            tbl_ok;

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;

  // lowest matching slot below the alphabet size
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = AlphaDepth - 1; i >= 0; i--) begin
      if (alpha[i] == item.symbol && SizeW'(i) < slot_limit) begin
        found = 1'b1;
        slot  = SlotW'(i);
      end
    end
  end

  assign tbl_ok = (5'(item.row_state) < 5'(Rows)) && (5'(item.column_index) < 5'(AlphaDepth));

  always_ff @(posedge clk) begin
    for (int i = 0; i < AlphaDepth; i++) begin
      if (accept && item.func == FN_ALPHA && item.column_index == SlotW'(i)) begin
        alpha[i] <= item.symbol;
      end
    end
  end

  always_comb begin
    push_cmd.is_symbol = (item.func == FN_SYMBOL);
    push_cmd.first     = item.first_of_string;
    push_cmd.found     = found;
    push_cmd.col       = (item.func == FN_SYMBOL) ? slot : item.column_index;
    push_cmd.row       = item.row_state;
    push_cmd.target    = item.target_state;
    push = accept && ((item.func == FN_SYMBOL) || (item.func == FN_TABLE && tbl_ok));
  end

endmodule
`default_nettype wire

>>> sv/dfam_queue.sv
`default_nettype none
module dfam_queue
  import dfam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      logic not_empty,
  output      cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

>>> sv/dfam_back.sv
`default_nettype none
module dfam_back
  import dfam_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int NUM_STATES  = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire walk_cfg_t cfg,
  input  wire logic      q_valid,
  input  wire cmd_t      head,
  output      logic      pop,
  dfam_result_if.source  result
);

  localparam int Rows  = (NUM_STATES < SlotMax) ? NUM_STATES : SlotMax;
  localparam int Cols  = (MAX_SYMBOLS < SlotMax) ? MAX_SYMBOLS : SlotMax;
  localparam int RowB  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int ColB  = (Cols > 1) ? $clog2(Cols) : 1;
  localparam int Depth = 1 << (RowB + ColB);
  localparam int CmpW  = 9;

  localparam logic S_RUN    = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic [StateW-1:0] mem [Depth];
  logic [StateW-1:0] rd_data;
  logic              state;
  logic [StateW-1:0] cur;
  logic              halted;
  logic [StateW-1:0] pend_before;
  logic              pend_oob;

  logic              out_free;
  logic [StateW-1:0] step_from;
  logic              halt_eff;
  logic              sym_pop;
  logic              tbl_we;
  logic              rd_en;
  logic [StateW-1:0] after;

  assign out_free  = !result.valid || result.ready;
  assign pop       = q_valid && state == S_RUN && out_free;
  assign sym_pop   = pop && head.is_symbol;
  assign tbl_we    = pop && !head.is_symbol;
  assign step_from = head.first ? cfg.initial_state : cur;
  assign halt_eff  = head.first ? 1'b0 : halted;
  assign rd_en     = sym_pop && !halt_eff && head.found;
  assign after     = pend_oob ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[{head.row[RowB-1:0], head.col[ColB-1:0]}] <= head.target;
    end
    if (rd_en) begin
      rd_data <= mem[{step_from[RowB-1:0], head.col[ColB-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      cur          <= '0;
      halted       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (sym_pop) begin
            cur                    <= step_from;
            result.state_before    <= step_from;
            result.accepted_before <= (step_from == cfg.accept_state);
            result.state_after     <= step_from;
            result.accepted_after  <= 1'b0;
            pend_before            <= step_from;
            pend_oob               <= (CmpW'(step_from) >= CmpW'(NUM_STATES));
            if (halt_eff) begin
              halted        <= 1'b1;
              result.status <= ST_IGNORED;
              result.valid  <= 1'b1;
            end else if (!head.found) begin
              halted        <= 1'b1;
              result.status <= ST_UNKNOWN;
              result.valid  <= 1'b1;
            end else begin
              halted       <= 1'b0;
              result.valid <= 1'b0;
              state        <= S_LOOKUP;
            end
          end else if (result.valid && result.ready) begin
            result.valid <= 1'b0;
          end
        end
        S_LOOKUP: begin
          cur                    <= after;
          result.state_before    <= pend_before;
          result.accepted_before <= (pend_before == cfg.accept_state);
          result.state_after     <= after;
          result.accepted_after  <= (after == cfg.accept_state);
          result.status          <= ST_OK;
          result.valid           <= 1'b1;
          state                  <= S_RUN;
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/table_driven_dfa_matcher_core.sv
`default_nettype none
// channel  dir  request
// item     in   load slot / load table entry / feed symbol
// result   out  one per fed symbol
// cfg      in   register write (initial, final, alphabet size)
//
// slot loads finish in the intake; table loads are written to the table in the walker
// a matched symbol goes through the synchronous table memory read, then the lookup
// state that registers its result; an unknown or ignored symbol registers its result at once
// a two-entry queue separates intake from the walker; intake stalls only when it fills
// synchronous reset clears state, halt flag and registers; stores are undefined until written
module table_driven_dfa_matcher_core
  import dfam_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int NUM_STATES  = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  dfam_item_if.sink     item,
  dfam_result_if.source result,
  dfam_cfg_if.sink      cfg
);

  logic [StateW-1:0] initial_state;
  logic [StateW-1:0] accept_state;
  logic [SizeW-1:0]  slot_limit;
  walk_cfg_t         walk_cfg;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state <= '0;
      accept_state  <= '0;
      slot_limit    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_INITIAL:    initial_state <= cfg.data[StateW-1:0];
        REG_FINAL:      accept_state  <= cfg.data[StateW-1:0];
        REG_ALPHA_SIZE: slot_limit    <= cfg.data[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign walk_cfg.initial_state = initial_state;
  assign walk_cfg.accept_state  = accept_state;

  dfam_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .NUM_STATES  (NUM_STATES)
  ) u_front (
    .clk        (clk),
    .item       (item),
    .slot_limit (slot_limit),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  dfam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  dfam_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .NUM_STATES  (NUM_STATES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (walk_cfg),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire
